[src/joint_pd_step_with_deadband_filter_macros.svh]
// Assertion macros used by the joint PD step controller RTL.
`ifndef JOINT_PD_STEP_WITH_DEADBAND_FILTER_MACROS_SVH
`define JOINT_PD_STEP_WITH_DEADBAND_FILTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/jpd_pkg.sv]
// Types and constants of the joint PD step controller.
`default_nettype none

package jpd_pkg;

  localparam int unsigned JointW   = 3;
  localparam int unsigned PosW     = 24;
  localparam int unsigned CfgW     = 64;
  localparam int unsigned AlphaW   = 17;
  localparam int unsigned StepW    = 17;
  localparam int unsigned ErrW     = 25;
  localparam int unsigned AccW     = 43;

  localparam logic [JointW-1:0] RegAlpha    = 3'd6;
  localparam logic [JointW-1:0] SettingRegs = 3'd6;

  localparam logic [AlphaW-1:0] AlphaOne   = 17'd65536;
  localparam logic [AlphaW-1:0] AlphaReset = 17'd16384;

  localparam logic [PosW-1:0] PosMax = 24'h7FFFFF;
  localparam logic [PosW-1:0] PosMin = 24'h800000;

  typedef struct packed {
    logic [15:0] kp;
    logic [15:0] kd;
    logic [15:0] max_step;
    logic [15:0] deadband;
  } jpd_gains_t;

  typedef struct packed {
    logic [AlphaW-1:0] alpha;
    logic [AlphaW-1:0] beta;
  } jpd_blend_t;

endpackage

`default_nettype wire

[src/jpd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module jpd_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 6,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/jpd_cfg.sv]
// Configuration registers: per-joint gains and the smoothing weight.
`default_nettype none

module jpd_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [jpd_pkg::JointW-1:0]  cfg_index_i,
  input  wire logic [jpd_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic [jpd_pkg::JointW-1:0]  joint_i,
  output jpd_pkg::jpd_gains_t              gains_o,
  output jpd_pkg::jpd_blend_t              blend_o
);

  import jpd_pkg::*;

  logic [CfgW-1:0]   settings_q [int'(SettingRegs)];
  logic [AlphaW-1:0] alpha_q;
  logic [AlphaW-1:0] alpha_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(SettingRegs); i++) begin
        settings_q[i] <= '0;
      end
      alpha_q <= AlphaReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i < SettingRegs) begin
        settings_q[cfg_index_i] <= cfg_data_i;
      end else if (cfg_index_i == RegAlpha) begin
        alpha_q <= cfg_data_i[AlphaW-1:0];
      end
    end
  end

  always_comb begin
    if (joint_i < SettingRegs) begin
      gains_o = jpd_gains_t'(settings_q[joint_i]);
    end else begin
      gains_o = '0;
    end
  end

  assign alpha_eff     = (alpha_q > AlphaOne) ? AlphaOne : alpha_q;
  assign blend_o.alpha = alpha_eff;
  assign blend_o.beta  = AlphaOne - alpha_eff;

endmodule

`default_nettype wire

[src/joint_pd_step_with_deadband_filter.sv]
// Joint PD step controller with error deadband, step clamp and output smoothing.
//
// Each transaction on the slave side is one control tick for one joint and yields
// exactly one transaction on the master side. The error is zeroed inside the joint's
// deadband, the step kp*error - kd*velocity is clamped to the joint's limit and blended
// with the joint's previous smoothed step, which is kept in a small state RAM of JOINTS
// entries that reads as zero until first written, so no clearing pass follows reset.
// Each item passes through the accepting cycle, four uses of the single 17 by 25 bit
// multiplier, a clamp step and a write-back step, which waits while the output register
// holds a result not yet taken; only then is the next item accepted. A new item is
// accepted while the previous result still waits in the output register.
`default_nettype none
`include "joint_pd_step_with_deadband_filter_macros.svh"

module joint_pd_step_with_deadband_filter #(
  parameter int unsigned JOINTS = 6
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // measured_position, measured_velocity, desired_position from bit 0 up
  input  wire logic [71:0]                s_tdata_i,
  // joint_index
  input  wire logic [jpd_pkg::JointW-1:0] s_tuser_i,
  input  wire logic                       s_tvalid_i,
  output logic                            s_tready_o,
  // commanded_position
  output logic [jpd_pkg::PosW-1:0]        m_tdata_o,
  // joint_number, range_clipped from bit 0 up
  output logic [jpd_pkg::JointW:0]        m_tuser_o,
  output logic                            m_tvalid_o,
  input  wire logic                       m_tready_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [jpd_pkg::JointW-1:0] cfg_index_i,
  input  wire logic [jpd_pkg::CfgW-1:0]   cfg_data_i
);

  import jpd_pkg::*;

  localparam int unsigned AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam logic [JointW:0] JointsCnt = (JointW + 1)'(JOINTS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_KP    = 7'b0000010,
    S_KD    = 7'b0000100,
    S_CLAMP = 7'b0001000,
    S_ALPHA = 7'b0010000,
    S_BETA  = 7'b0100000,
    S_FIN   = 7'b1000000
  } jpd_state_e;

  jpd_state_e state_q, state_d;

  logic signed [PosW-1:0] in_meas, in_vel, in_des;
  logic [JointW-1:0]      lookup_joint;
  jpd_gains_t             gains;
  jpd_blend_t             blend;

  logic                   in_acc, in_range;
  logic signed [ErrW-1:0] err_raw, err_db;
  logic [ErrW-1:0]        err_mag;

  logic [JointW-1:0]      joint_q;
  logic                   in_range_q, vld_rd_q;
  logic signed [PosW-1:0] meas_q;
  logic signed [ErrW-1:0] err_q, vneg_q;
  logic signed [StepW-1:0] step_q, step_d, prev_q;
  logic signed [AccW-1:0] acc_q, acc_d, clamped, lim;

  logic [AlphaW-1:0]      mul_a;
  logic signed [ErrW-1:0] mul_b;
  logic signed [AccW-1:0] mul_p;

  logic [JOINTS-1:0]      vld_q;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [StepW-1:0]       ram_rdata;

  logic                   fin_go;
  logic signed [StepW-1:0] s_new;
  logic signed [PosW:0]   cmd_w;
  logic [PosW-1:0]        cmd;
  logic                   clip;

  logic                   m_valid_q;
  logic [PosW-1:0]        m_data_q;
  logic [JointW:0]        m_user_q;

  assign in_meas = s_tdata_i[PosW-1:0];
  assign in_vel  = s_tdata_i[2*PosW-1:PosW];
  assign in_des  = s_tdata_i[3*PosW-1:2*PosW];

  assign s_tready_o = (state_q == S_IDLE);
  assign in_acc     = s_tvalid_i && s_tready_o;
  assign in_range   = ({1'b0, s_tuser_i} < JointsCnt);

  assign lookup_joint = (state_q == S_IDLE) ? s_tuser_i : joint_q;

  jpd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .joint_i     (lookup_joint),
    .gains_o     (gains),
    .blend_o     (blend)
  );

  assign err_raw = ErrW'(in_des) - ErrW'(in_meas);
  assign err_mag = err_raw[ErrW-1] ? ErrW'(-err_raw) : err_raw;
  assign err_db  = (err_mag < ErrW'(gains.deadband)) ? '0 : err_raw;

  always_comb begin
    unique case (state_q)
      S_KP: begin
        mul_a = AlphaW'(gains.kp);
        mul_b = err_q;
      end
      S_KD: begin
        mul_a = AlphaW'(gains.kd);
        mul_b = vneg_q;
      end
      S_ALPHA: begin
        mul_a = blend.alpha;
        mul_b = ErrW'(step_q);
      end
      S_BETA: begin
        mul_a = blend.beta;
        mul_b = ErrW'(prev_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = AccW'($signed({1'b0, mul_a})) * AccW'(mul_b);

  assign lim = $signed({15'd0, gains.max_step, 12'd0});

  always_comb begin
    priority if (acc_q > lim) begin
      clamped = lim;
    end else if (acc_q < -lim) begin
      clamped = -lim;
    end else begin
      clamped = acc_q;
    end
  end

  assign step_d = clamped[StepW+11:12];

  always_comb begin
    unique case (state_q)
      S_KP, S_ALPHA: acc_d = mul_p;
      S_KD, S_BETA:  acc_d = acc_q + mul_p;
      default:       acc_d = acc_q;
    endcase
  end

  assign fin_go = (state_q == S_FIN) && (!m_valid_q || m_tready_i);

  always_comb begin
    unique case (state_q)
      S_IDLE:  state_d = in_acc ? S_KP : S_IDLE;
      S_KP:    state_d = S_KD;
      S_KD:    state_d = S_CLAMP;
      S_CLAMP: state_d = S_ALPHA;
      S_ALPHA: state_d = S_BETA;
      S_BETA:  state_d = S_FIN;
      S_FIN:   state_d = fin_go ? S_IDLE : S_FIN;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      joint_q    <= s_tuser_i;
      in_range_q <= in_range;
      vld_rd_q   <= in_range && vld_q[s_tuser_i[AW-1:0]];
      meas_q     <= in_meas;
      err_q      <= err_db;
      vneg_q     <= -ErrW'(in_vel);
    end
    if (state_q == S_KP) begin
      prev_q <= vld_rd_q ? $signed(ram_rdata) : '0;
    end
    if (state_q == S_CLAMP) begin
      step_q <= step_d;
    end
    acc_q <= acc_d;
  end

  assign s_new     = acc_q[StepW+15:16];
  assign ram_we    = fin_go && in_range_q;
  assign ram_waddr = joint_q[AW-1:0];

  jpd_ram #(
    .WIDTH (StepW),
    .DEPTH (JOINTS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s_new),
    .re_i    (in_acc && in_range),
    .raddr_i (s_tuser_i[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ram_we) begin
      vld_q[ram_waddr] <= 1'b1;
    end
  end

  assign cmd_w = (PosW + 1)'(meas_q) + (PosW + 1)'(s_new);

  always_comb begin
    if (!in_range_q) begin
      cmd  = meas_q;
      clip = 1'b0;
    end else if (cmd_w[PosW] != cmd_w[PosW-1]) begin
      cmd  = cmd_w[PosW] ? PosMin : PosMax;
      clip = 1'b1;
    end else begin
      cmd  = cmd_w[PosW-1:0];
      clip = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (fin_go) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      m_data_q <= cmd;
      m_user_q <= {clip, joint_q};
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_user_q;

  `JPD_ASSERT_NEXT(a_accept_starts_item, in_acc, state_q == S_KP, "accepted item did not start")
  `JPD_ASSERT_NEXT(a_fin_gives_result, fin_go, m_tvalid_o, "finished item gave no result")
  `JPD_ASSERT_NEXT(a_write_sets_valid, ram_we, vld_q[$past(ram_waddr)], "state entry not marked")
  `JPD_ASSERT_SAME(a_clip_is_extreme, m_tvalid_o && m_tuser_o[JointW], (m_tdata_o == PosMax) || (m_tdata_o == PosMin), "clipped result not at a range limit")

endmodule

`default_nettype wire

[sim/joint_pd_step_with_deadband_filter_checker.sv]
// Checker for the joint PD step controller: predicts each command and compares the results.
module joint_pd_step_with_deadband_filter_checker #(
  parameter int unsigned JOINTS = 6
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [71:0]                s_tdata_i,
  input  wire logic [jpd_pkg::JointW-1:0] s_tuser_i,
  input  wire logic                       s_tvalid_i,
  input  wire logic                       s_tready_o,
  input  wire logic [jpd_pkg::PosW-1:0]   m_tdata_o,
  input  wire logic [jpd_pkg::JointW:0]   m_tuser_o,
  input  wire logic                       m_tvalid_o,
  input  wire logic                       m_tready_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [jpd_pkg::JointW-1:0] cfg_index_i,
  input  wire logic [jpd_pkg::CfgW-1:0]   cfg_data_i,
  output int unsigned                     mismatches_o,
  output int unsigned                     pending_o,
  output int unsigned                     checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import jpd_pkg::*;

  localparam int unsigned GainShift  = 12;
  localparam int unsigned BlendShift = 16;

  typedef struct packed {
    logic [JointW-1:0] joint;
    logic [PosW-1:0]   position;
    logic              clipped;
  } command_t;

  jpd_gains_t              joint_gains [8];
  logic signed [StepW-1:0] smoothed_steps [8];
  logic [AlphaW-1:0]       blend_weight;
  command_t                pending_cmds [$];

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  function automatic command_t plan_command(input logic [JointW-1:0] joint,
                                            input logic signed [PosW-1:0] meas,
                                            input logic signed [PosW-1:0] vel,
                                            input logic signed [PosW-1:0] des);
    command_t   cmd;
    jpd_gains_t g;
    longint     m, v, d, a, err, mag, push, lim, step, prev, blend, sum, pos_hi, pos_lo;
    cmd.joint    = joint;
    cmd.position = meas;
    cmd.clipped  = 1'b0;
    if (joint < JOINTS) begin
      g = joint_gains[joint];
      m = meas;
      v = vel;
      d = des;
      a = (blend_weight > AlphaOne) ? longint'(AlphaOne) : longint'(blend_weight);
      err = d - m;
      mag = (err < 0) ? -err : err;
      if (mag < longint'(g.deadband)) begin
        err = 0;
      end
      push = longint'(g.kp) * err - longint'(g.kd) * v;
      lim = longint'(g.max_step) <<< GainShift;
      if (push > lim) begin
        push = lim;
      end
      if (push < -lim) begin
        push = -lim;
      end
      step = push >>> GainShift;
      prev = smoothed_steps[joint];
      blend = (a * step + (longint'(AlphaOne) - a) * prev) >>> BlendShift;
      smoothed_steps[joint] = blend[StepW-1:0];
      pos_hi = longint'(PosMax);
      pos_lo = -pos_hi - 1;
      sum = m + blend;
      if (sum > pos_hi) begin
        sum = pos_hi;
        cmd.clipped = 1'b1;
      end
      if (sum < pos_lo) begin
        sum = pos_lo;
        cmd.clipped = 1'b1;
      end
      cmd.position = sum[PosW-1:0];
    end
    return cmd;
  endfunction

  task automatic report_mismatch(input string what, input longint expected,
                                 input longint actual);
    $display("%0t ns: mismatch in %s, expected %0h, got %0h", $time, what, expected, actual);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    command_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        joint_gains[i]    = '0;
        smoothed_steps[i] = '0;
      end
      blend_weight = AlphaReset;
      pending_cmds.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i < SettingRegs) begin
          joint_gains[cfg_index_i] = cfg_data_i;
        end else if (cfg_index_i == RegAlpha) begin
          blend_weight = cfg_data_i[AlphaW-1:0];
        end
      end
      if (m_tvalid_o && m_tready_i) begin
        if (pending_cmds.size() == 0) begin
          report_mismatch("unexpected command transaction", 0, m_tdata_o);
        end else begin
          want = pending_cmds.pop_front();
          checked_o++;
          if (m_tuser_o[JointW-1:0] !== want.joint) begin
            report_mismatch("joint_number", want.joint, m_tuser_o[JointW-1:0]);
          end
          if (m_tdata_o !== want.position) begin
            report_mismatch("commanded_position", want.position, m_tdata_o);
          end
          if (m_tuser_o[JointW] !== want.clipped) begin
            report_mismatch("range_clipped", want.clipped, m_tuser_o[JointW]);
          end
        end
      end
      if (s_tvalid_i && s_tready_o) begin
        pending_cmds = {pending_cmds, plan_command(s_tuser_i, s_tdata_i[23:0],
                                                   s_tdata_i[47:24], s_tdata_i[71:48])};
      end
      pending_o = pending_cmds.size();
    end
  end

endmodule

[sim/joint_pd_step_with_deadband_filter_test.sv]
// Testbench top for the joint PD step controller: clock, reset, stimulus and verdict.
module joint_pd_step_with_deadband_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jpd_pkg::*;

  localparam int unsigned Joints        = 6;
  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned RandomPhases  = 6;
  localparam int unsigned TicksPerPhase = 213;
  localparam logic [JointW-1:0] RegSpare = 3'd7;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic [71:0]         s_tdata_i   = '0;
  logic [JointW-1:0]   s_tuser_i   = '0;
  logic                s_tvalid_i  = 1'b0;
  logic                s_tready_o;
  logic [PosW-1:0]     m_tdata_o;
  logic [JointW:0]     m_tuser_o;
  logic                m_tvalid_o;
  logic                m_tready_i  = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [JointW-1:0]   cfg_index_i = '0;
  logic [CfgW-1:0]     cfg_data_i  = '0;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned checked_cnt;
  int unsigned cycle_cnt   = 0;
  int unsigned stall_left  = 0;
  int unsigned ticks_sent  = 0;
  int unsigned writes_sent = 0;
  bit          calm        = 1'b0;

  joint_pd_step_with_deadband_filter #(
    .JOINTS(Joints)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  joint_pd_step_with_deadband_filter_checker #(
    .JOINTS(Joints)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mismatches_o(mismatch_cnt),
    .pending_o   (pending_cnt),
    .checked_o   (checked_cnt)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d commands outstanding.", cycle_cnt,
               pending_cnt);
      $display("joint_pd_step_with_deadband_filter_test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_tready_i <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  task automatic write_reg(input logic [JointW-1:0] index, input logic [CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    writes_sent++;
    @(posedge clk_i);
  endtask

  task automatic write_joint(input logic [JointW-1:0] joint, input logic [15:0] kp,
                             input logic [15:0] kd, input logic [15:0] max_step,
                             input logic [15:0] deadband);
    jpd_gains_t g;
    g.kp       = kp;
    g.kd       = kd;
    g.max_step = max_step;
    g.deadband = deadband;
    write_reg(joint, g);
  endtask

  task automatic send_tick(input logic [JointW-1:0] joint, input logic [PosW-1:0] meas,
                           input logic [PosW-1:0] vel, input logic [PosW-1:0] des);
    int unsigned gap;
    cfg_we_i <= 1'b0;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tdata_i  <= {des, vel, meas};
    s_tuser_i  <= joint;
    s_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_tready_o);
    ticks_sent++;
  endtask

  task automatic settle();
    s_tvalid_i <= 1'b0;
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [PosW-1:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return PosMax;
      1: return PosMin;
      2, 3: return PosW'($urandom_range(0, 4095)) - PosW'(2048);
      default: return PosW'($urandom);
    endcase
  endfunction

  task automatic send_random_tick();
    logic [JointW-1:0] joint;
    logic [PosW-1:0]   meas;
    logic [PosW-1:0]   vel;
    logic [PosW-1:0]   des;
    if ($urandom_range(0, 7) == 0) begin
      joint = JointW'($urandom_range(Joints, 7));
    end else begin
      joint = JointW'($urandom_range(0, Joints - 1));
    end
    meas = rand_pos();
    vel  = ($urandom_range(0, 2) == 0) ? rand_pos() : PosW'($urandom_range(0, 255)) - PosW'(128);
    if ($urandom_range(0, 1) == 0) begin
      des = meas + PosW'($urandom_range(0, 4095)) - PosW'(2048);
    end else begin
      des = rand_pos();
    end
    send_tick(joint, meas, vel, des);
  endtask

  initial begin
    logic [AlphaW-1:0] alpha_pick;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the reset gains every command equals the measured position.
    send_tick(3'd0, PosMax, PosMin, PosMin);
    send_tick(3'd5, PosMin, PosMax, PosMax);
    settle();

    write_joint(3'd0, 16'h1000, 16'h0001, 16'h4000, 16'h0100);
    write_joint(3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_joint(3'd2, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    write_joint(3'd3, 16'h2000, 16'h0000, 16'hFFFF, 16'hFFFF);
    write_joint(3'd4, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    write_joint(3'd5, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    write_reg(RegAlpha, CfgW'(AlphaOne));
    write_reg(RegSpare, {$urandom, $urandom});

    // Deadband edges, a negative step that must round down, and both saturations.
    send_tick(3'd0, 24'h001000, 24'h000000, 24'h0010FF);
    send_tick(3'd0, 24'h001000, 24'h000000, 24'h001100);
    send_tick(3'd0, 24'h001000, 24'h000000, 24'h000F00);
    send_tick(3'd0, 24'h001000, 24'h000000, 24'h000F01);
    send_tick(3'd0, 24'h000000, 24'h000001, 24'h000000);
    send_tick(3'd3, 24'h000000, 24'h000000, 24'h00FFFE);
    send_tick(3'd3, 24'h000000, 24'h000000, 24'h00FFFF);
    send_tick(3'd1, PosMax, PosMin, PosMax);
    send_tick(3'd1, PosMin, PosMax, PosMin);
    send_tick(3'd2, 24'h000000, 24'h000000, PosMax);
    send_tick(3'd2, PosMax, 24'h000000, PosMin);
    send_tick(3'd4, 24'h000000, 24'h000123, 24'h000000);
    send_tick(3'd4, 24'h000000, 24'hFFFEDD, 24'h000000);
    send_tick(3'd5, 24'h000000, PosMin, PosMax);
    send_tick(3'd6, PosMax, PosMax, PosMin);
    send_tick(3'd7, PosMin, PosMin, PosMax);
    settle();

    write_reg(RegAlpha, CfgW'(17'h1FFFF));
    send_tick(3'd2, 24'h000000, 24'h000000, PosMin);
    settle();
    write_reg(RegAlpha, CfgW'(17'd0));
    send_tick(3'd2, 24'h000000, 24'h000000, PosMax);
    send_tick(3'd2, PosMax, 24'h000000, PosMax);
    settle();
    write_reg(RegAlpha, CfgW'(17'd1));
    send_tick(3'd1, 24'h000000, PosMin, 24'h000000);
    send_tick(3'd0, 24'h000000, 24'h000000, 24'h000400);
    settle();

    for (int phase = 0; phase < RandomPhases; phase++) begin
      if (phase == RandomPhases - 1) begin
        calm = 1'b1;
      end
      for (int j = 0; j < Joints; j++) begin
        write_joint(JointW'(j), rand_gain(), rand_gain(), rand_gain(), rand_gain());
      end
      case (phase)
        0: alpha_pick = AlphaOne;
        1: alpha_pick = 17'd0;
        2: alpha_pick = 17'h1FFFF;
        3: alpha_pick = AlphaW'($urandom_range(0, 17'h1FFFF));
        4: alpha_pick = 17'd1;
        default: alpha_pick = AlphaReset;
      endcase
      write_reg(RegAlpha, CfgW'(alpha_pick));
      write_reg(RegSpare, {$urandom, $urandom});
      repeat (TicksPerPhase) send_random_tick();
      settle();
    end

    $display("Sent %0d control ticks and %0d register writes; %0d commands were checked.",
             ticks_sent, writes_sent, checked_cnt);
    $display("Covered deadband edges, step clamps, range saturation, idle joints and %0d %s",
             RandomPhases, "random gain and smoothing settings.");
    if (mismatch_cnt == 0) begin
      $display("joint_pd_step_with_deadband_filter_test passed");
    end else begin
      $display("joint_pd_step_with_deadband_filter_test failed");
    end
    $finish;
  end

endmodule
